/* src/cpa_pkg.sv */
package cpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int LEN_W     = $clog2(NUM_PAGES + 1);
  localparam int WORD_W    = LEN_W + 1;

  // request kinds
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // page pointer updates
  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_BASE, PTR_PICK, PTR_END, PTR_BELOW, PTR_HDEC, PTR_INC
  } ptr_op_t;

  // write data select
  typedef enum logic [2:0] {
    WD_ZERO, WD_FREE, WD_MARK, WD_LRUN, WD_MERGE, WD_REM
  } wd_sel_t;

  // write address select
  typedef enum logic [1:0] {
    WA_PTR, WA_BASE, WA_H
  } wa_sel_t;

  typedef struct packed {
    logic       cap;
    ptr_op_t    ptr_op;
    logic       rd;
    logic       wr;
    wa_sel_t    wa;
    wd_sel_t    wd;
    logic       eval_chk;
    logic       eval_fit;
    logic       clr_flags;
    logic       tot_add;
    logic       tot_sub;
    logic       l_load;
    logic       l_add;
    logic       h_load;
    logic       resp;
    logic [1:0] code;
    logic       give_base;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       n_zero;
    logic       range_bad;
    logic       n_gt_total;
    logic       end_in;
    logic       base_zero;
    logic       ptr_last;
    logic       ptr_max;
    logic       rd_free;
    logic       found;
    logic       bad_flag;
    logic       policy;
    logic       best_gt_n;
    logic       hlen_zero;
    logic       h_zero;
  } stat_t;

endpackage

/* src/cpa_ram.sv */
module cpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/cpa_datapath.sv */
module cpa_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  cpa_pkg::cmd_t             cmd,
  output cpa_pkg::stat_t            stat,
  input  logic [1:0]                req_type,
  input  logic [cpa_pkg::PAGE_W-1:0] base_page,
  input  logic [cpa_pkg::LEN_W-1:0] page_count,
  input  logic                      cfg_valid,
  input  logic                      cfg_data,
  output logic                      done,
  output logic [1:0]                status,
  output logic [cpa_pkg::PAGE_W-1:0] alloc_base,
  output logic [cpa_pkg::LEN_W-1:0] free_total
);

  localparam int PW = cpa_pkg::PAGE_W;
  localparam int LW = cpa_pkg::LEN_W;
  localparam int WW = cpa_pkg::WORD_W;

  logic [1:0]    rtype;
  logic [PW-1:0] base;
  logic [LW-1:0] n;
  logic [PW-1:0] ptr;
  logic [PW-1:0] rd_addr_q;
  logic          rdv;
  logic          bad_flag;
  logic          found;
  logic [PW-1:0] pick;
  logic [LW-1:0] best;
  logic [LW-1:0] lrun;
  logic [PW-1:0] hptr;
  logic [LW-1:0] hlen;
  logic [LW-1:0] total;
  logic          policy;

  logic [WW-1:0] rdata;
  logic [WW-1:0] wdata;
  logic [PW-1:0] waddr;
  logic          rd_free;
  logic [LW-1:0] rd_len;
  logic [LW:0]   end_sum;
  logic [PW-1:0] rbase;
  logic [PW-1:0] last_addr;
  logic          fit_hit;

  assign rd_free = rdata[WW-1];
  assign rd_len  = rdata[LW-1:0];
  assign end_sum = (LW+1)'(base) + (LW+1)'(n);
  assign rbase   = (rtype == cpa_pkg::REQ_ALLOC) ? pick : base;
  assign last_addr = PW'((LW+1)'(rbase) + (LW+1)'(n) - (LW+1)'(1));
  assign fit_hit = rdv && rd_free && (rd_len >= n) && (!found || (policy && rd_len < best));

  // page store: free mark over run length
  cpa_ram #(.WIDTH(WW), .DEPTH(cpa_pkg::NUM_PAGES)) u_store (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (ptr),
    .rdata (rdata)
  );

  // write address and data selection
  always_comb begin
    case (cmd.wa)
      cpa_pkg::WA_BASE: waddr = base;
      cpa_pkg::WA_H:    waddr = hptr;
      default:          waddr = ptr;
    endcase
    case (cmd.wd)
      cpa_pkg::WD_FREE:  wdata = {1'b1, {LW{1'b0}}};
      cpa_pkg::WD_MARK:  wdata = {1'b1, (ptr == base && rtype == cpa_pkg::REQ_INIT) ? n
                                                                              : {LW{1'b0}}};
      cpa_pkg::WD_LRUN:  wdata = {1'b1, lrun};
      cpa_pkg::WD_MERGE: wdata = {1'b1, LW'(hlen + lrun)};
      cpa_pkg::WD_REM:   wdata = {1'b1, LW'(best - n)};
      default:           wdata = '0;
    endcase
  end

  // status to the controller
  always_comb begin
    stat.req_type   = rtype;
    stat.n_zero     = (n == '0);
    stat.range_bad  = (end_sum > (LW+1)'(cpa_pkg::NUM_PAGES));
    stat.n_gt_total = (n > total);
    stat.end_in     = (end_sum < (LW+1)'(cpa_pkg::NUM_PAGES));
    stat.base_zero  = (base == '0);
    stat.ptr_last   = (ptr == last_addr);
    stat.ptr_max    = (ptr == PW'(cpa_pkg::NUM_PAGES - 1));
    stat.rd_free    = rd_free;
    stat.found      = found;
    stat.bad_flag   = bad_flag;
    stat.policy     = policy;
    stat.best_gt_n  = (best > n);
    stat.hlen_zero  = (hlen == '0);
    stat.h_zero     = (hptr == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rdv      <= 1'b0;
      bad_flag <= 1'b0;
      found    <= 1'b0;
      total    <= '0;
      policy   <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        policy <= cfg_data;
      end
      case (cmd.ptr_op)
        cpa_pkg::PTR_ZERO:  ptr <= '0;
        cpa_pkg::PTR_BASE:  ptr <= base;
        cpa_pkg::PTR_PICK:  ptr <= pick;
        cpa_pkg::PTR_END:   ptr <= PW'(end_sum);
        cpa_pkg::PTR_BELOW: ptr <= base - PW'(1);
        cpa_pkg::PTR_HDEC:  ptr <= hptr - PW'(1);
        cpa_pkg::PTR_INC:   ptr <= ptr + PW'(1);
        default:            ptr <= ptr;
      endcase
      rdv <= cmd.rd;
      if (cmd.clr_flags) begin
        bad_flag <= 1'b0;
        found    <= 1'b0;
      end else begin
        if (cmd.eval_chk && rdv && rd_free) begin
          bad_flag <= 1'b1;
        end
        if (cmd.eval_fit && fit_hit) begin
          found <= 1'b1;
        end
      end
      if (cmd.tot_add) begin
        total <= total + n;
      end else if (cmd.tot_sub) begin
        total <= total - n;
      end
      done <= cmd.resp;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rtype <= req_type;
      base  <= base_page;
      n     <= page_count;
    end
    rd_addr_q <= ptr;
    if (cmd.eval_fit && fit_hit) begin
      pick <= rd_addr_q;
      best <= rd_len;
    end
    if (cmd.l_load) begin
      lrun <= n;
    end else if (cmd.l_add) begin
      lrun <= LW'(lrun + rd_len);
    end
    if (cmd.h_load) begin
      hptr <= rd_addr_q;
      hlen <= rd_len;
    end
    if (cmd.resp) begin
      status     <= cmd.code;
      alloc_base <= cmd.give_base ? pick : '0;
      free_total <= total;
    end
  end

endmodule

/* src/cpa_ctrl.sv */
module cpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cpa_pkg::stat_t stat,
  output cpa_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    CLR, IDLE, DISP, CHK, CHK_DR, CHK_DEC, MARK,
    F_END, F_END_RD, F_END_EV, F_BL, F_BL_RD, F_BL_EV, F_WALK, F_WALK_RD, F_WALK_EV,
    AS, AS_DR, AS_DEC, AW, AR
  } state_t;

  state_t state, state_next;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    cmd.ptr_op = cpa_pkg::PTR_HOLD;
    cmd.wa     = cpa_pkg::WA_PTR;
    cmd.wd     = cpa_pkg::WD_ZERO;
    state_next = state;
    case (state)
      CLR: begin
        cmd.wr     = 1'b1;
        cmd.ptr_op = cpa_pkg::PTR_INC;
        if (stat.ptr_max) state_next = IDLE;
      end
      IDLE: begin
        if (start) begin
          cmd.cap    = 1'b1;
          state_next = DISP;
        end
      end
      DISP: begin
        cmd.clr_flags = 1'b1;
        if (stat.req_type == cpa_pkg::REQ_ALLOC) begin
          if (stat.n_zero || stat.n_gt_total) begin
            cmd.resp   = 1'b1;
            cmd.code   = stat.n_zero ? cpa_pkg::ST_BAD : cpa_pkg::ST_NOFIT;
            state_next = IDLE;
          end else begin
            cmd.ptr_op = cpa_pkg::PTR_ZERO;
            state_next = AS;
          end
        end else if (stat.req_type inside {cpa_pkg::REQ_INIT, cpa_pkg::REQ_FREE}
                     && !stat.n_zero && !stat.range_bad) begin
          cmd.ptr_op = cpa_pkg::PTR_BASE;
          state_next = CHK;
        end else begin
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_BAD;
          state_next = IDLE;
        end
      end
      // range must hold no free page
      CHK: begin
        cmd.rd       = 1'b1;
        cmd.eval_chk = 1'b1;
        cmd.ptr_op   = cpa_pkg::PTR_INC;
        if (stat.ptr_last) state_next = CHK_DR;
      end
      CHK_DR: begin
        cmd.eval_chk = 1'b1;
        state_next   = CHK_DEC;
      end
      CHK_DEC: begin
        if (stat.bad_flag) begin
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_BAD;
          state_next = IDLE;
        end else begin
          cmd.ptr_op  = cpa_pkg::PTR_BASE;
          cmd.tot_add = 1'b1;
          state_next  = MARK;
        end
      end
      MARK: begin
        cmd.wr     = 1'b1;
        cmd.wd     = cpa_pkg::WD_MARK;
        cmd.ptr_op = cpa_pkg::PTR_INC;
        if (stat.ptr_last) begin
          if (stat.req_type == cpa_pkg::REQ_INIT) begin
            cmd.resp   = 1'b1;
            cmd.code   = cpa_pkg::ST_DONE;
            state_next = IDLE;
          end else begin
            cmd.l_load = 1'b1;
            state_next = F_END;
          end
        end
      end
      // merge with the run that follows
      F_END: begin
        if (stat.end_in) begin
          cmd.ptr_op = cpa_pkg::PTR_END;
          state_next = F_END_RD;
        end else begin
          state_next = F_BL;
        end
      end
      F_END_RD: begin
        cmd.rd     = 1'b1;
        state_next = F_END_EV;
      end
      F_END_EV: begin
        if (stat.rd_free) begin
          cmd.l_add = 1'b1;
          cmd.wr    = 1'b1;
          cmd.wd    = cpa_pkg::WD_FREE;
        end
        state_next = F_BL;
      end
      // merge with the run that precedes
      F_BL: begin
        if (stat.base_zero) begin
          cmd.wr     = 1'b1;
          cmd.wa     = cpa_pkg::WA_BASE;
          cmd.wd     = cpa_pkg::WD_LRUN;
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_DONE;
          state_next = IDLE;
        end else begin
          cmd.ptr_op = cpa_pkg::PTR_BELOW;
          state_next = F_BL_RD;
        end
      end
      F_BL_RD: begin
        cmd.rd     = 1'b1;
        state_next = F_BL_EV;
      end
      F_BL_EV: begin
        if (!stat.rd_free) begin
          cmd.wr     = 1'b1;
          cmd.wa     = cpa_pkg::WA_BASE;
          cmd.wd     = cpa_pkg::WD_LRUN;
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_DONE;
          state_next = IDLE;
        end else begin
          cmd.h_load = 1'b1;
          state_next = F_WALK;
        end
      end
      // walk down to the head of the lower run
      F_WALK: begin
        if (stat.hlen_zero && !stat.h_zero) begin
          cmd.ptr_op = cpa_pkg::PTR_HDEC;
          state_next = F_WALK_RD;
        end else begin
          cmd.wr     = 1'b1;
          cmd.wa     = cpa_pkg::WA_H;
          cmd.wd     = cpa_pkg::WD_MERGE;
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_DONE;
          state_next = IDLE;
        end
      end
      F_WALK_RD: begin
        cmd.rd     = 1'b1;
        state_next = F_WALK_EV;
      end
      F_WALK_EV: begin
        if (stat.rd_free) begin
          cmd.h_load = 1'b1;
          state_next = F_WALK;
        end else begin
          cmd.wr     = 1'b1;
          cmd.wa     = cpa_pkg::WA_H;
          cmd.wd     = cpa_pkg::WD_MERGE;
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_DONE;
          state_next = IDLE;
        end
      end
      // allocation scan in address order
      AS: begin
        cmd.rd       = 1'b1;
        cmd.eval_fit = 1'b1;
        cmd.ptr_op   = cpa_pkg::PTR_INC;
        if (stat.ptr_max || (stat.found && !stat.policy)) state_next = AS_DR;
      end
      AS_DR: begin
        cmd.eval_fit = 1'b1;
        state_next   = AS_DEC;
      end
      AS_DEC: begin
        if (!stat.found) begin
          cmd.resp   = 1'b1;
          cmd.code   = cpa_pkg::ST_NOFIT;
          state_next = IDLE;
        end else begin
          cmd.ptr_op  = cpa_pkg::PTR_PICK;
          cmd.tot_sub = 1'b1;
          state_next  = AW;
        end
      end
      AW: begin
        cmd.wr     = 1'b1;
        cmd.ptr_op = cpa_pkg::PTR_INC;
        if (stat.ptr_last) state_next = AR;
      end
      AR: begin
        if (stat.best_gt_n) begin
          cmd.wr = 1'b1;
          cmd.wd = cpa_pkg::WD_REM;
        end
        cmd.resp      = 1'b1;
        cmd.code      = cpa_pkg::ST_DONE;
        cmd.give_base = 1'b1;
        state_next    = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
    end
  end

endmodule

/* src/contiguous_page_allocator.sv */
// Contiguous page allocator.
// Request channel: start with req_type, base_page, page_count is taken at a
// clock edge where start is high and busy is low. Kinds: init a reserved
// range as free, allocate page_count pages, free a range.
// Result: done pulses for one cycle with status, alloc_base and free_total;
// the receiver cannot stall, so results are never held back.
// Config channel: cfg_valid/cfg_ready carry fit_policy (0 first fit, 1 best
// fit); cfg_ready is always high, write it only while idle.
// One request at a time through a single page store with one read
// and one write port and a registered read:
//   init: check scan, then mark pass
//   free: check scan and mark pass, then merges, stepping down page by page on
//     the way to the head of the lower run
//   alloc: a scan of the store, then a pass to claim the pages;
//     first fit ends the scan after the first run that fits.
// Reset: a clearing pass writes all NUM_PAGES entries, one a cycle, with
// busy high; config writes are taken during it.
module contiguous_page_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic [cpa_pkg::PAGE_W-1:0] base_page,
  input  logic [cpa_pkg::LEN_W-1:0]  page_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [cpa_pkg::PAGE_W-1:0] alloc_base,
  output logic [cpa_pkg::LEN_W-1:0]  free_total
);

  cpa_pkg::cmd_t  cmd;
  cpa_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  cpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cpa_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .base_page  (base_page),
    .page_count (page_count),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .alloc_base (alloc_base),
    .free_total (free_total)
  );

endmodule

/* sim/testbench.sv */
module testbench;

  localparam int NP = cpa_pkg::NUM_PAGES;
  localparam int CYCLE_LIMIT = 8000000;
  localparam logic [1:0] REQ_BOGUS = 2'd3;

  typedef struct packed {
    logic [1:0]                 st;
    logic [cpa_pkg::PAGE_W-1:0] ab;
    logic [cpa_pkg::LEN_W-1:0]  tot;
  } alloc_result_t;

  typedef struct {
    logic [1:0] kind;
    int         b;
    int         n;
    bit         typed;
    logic [1:0] st;
    int         ab;
    int         tot;
  } req_row_t;

  logic clk, rst, start, cfg_valid, cfg_data;
  logic [1:0] req_type;
  logic [cpa_pkg::PAGE_W-1:0] base_page;
  logic [cpa_pkg::LEN_W-1:0] page_count;
  logic busy, cfg_ready, done;
  logic [1:0] status;
  logic [cpa_pkg::PAGE_W-1:0] alloc_base;
  logic [cpa_pkg::LEN_W-1:0] free_total;

  // shadow of the page store
  bit pg_free [NP];
  int pg_len [NP];
  int pg_total;
  bit fit_best;

  alloc_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int burst_left = 0;

  contiguous_page_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .base_page(base_page), .page_count(page_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .alloc_base(alloc_base),
    .free_total(free_total)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // range lies inside the store and holds no free page
  function automatic bit range_reserved(int b, int n);
    if (n == 0 || b >= NP || n > NP - b) return 0;
    for (int i = b; i < b + n; i++)
      if (pg_free[i]) return 0;
    return 1;
  endfunction

  function automatic void release_range(int b, int n);
    for (int i = b; i < b + n; i++) begin
      pg_free[i] = 1;
      pg_len[i] = 0;
    end
    pg_len[b] = n;
    pg_total += n;
  endfunction

  // expected outcome of one request; updates the shadow store
  function automatic alloc_result_t page_request(logic [1:0] kind, int b, int n);
    alloc_result_t r;
    int pick, best, h;
    bit found;
    logic [1:0] st;
    st = cpa_pkg::ST_BAD;
    pick = 0;
    best = 0;
    found = 0;
    if (kind == cpa_pkg::REQ_INIT) begin
      if (range_reserved(b, n)) begin
        release_range(b, n);
        st = cpa_pkg::ST_DONE;
      end
    end else if (kind == cpa_pkg::REQ_ALLOC) begin
      if (n == 0) st = cpa_pkg::ST_BAD;
      else if (n > pg_total) st = cpa_pkg::ST_NOFIT;
      else begin
        for (int i = 0; i < NP; i++) begin
          if (pg_free[i] && pg_len[i] >= n && (!found || pg_len[i] < best)) begin
            found = 1;
            pick = i;
            best = pg_len[i];
            if (!fit_best) break;
          end
        end
        if (!found) st = cpa_pkg::ST_NOFIT;
        else begin
          for (int i = pick; i < pick + n; i++) begin
            pg_free[i] = 0;
            pg_len[i] = 0;
          end
          if (best > n) pg_len[pick + n] = best - n;
          pg_total -= n;
          st = cpa_pkg::ST_DONE;
        end
      end
      if (st != cpa_pkg::ST_DONE) pick = 0;
    end else if (kind == cpa_pkg::REQ_FREE) begin
      if (range_reserved(b, n)) begin
        release_range(b, n);
        // merge with run above, then with run below
        if (b + n < NP && pg_free[b + n]) begin
          pg_len[b] += pg_len[b + n];
          pg_len[b + n] = 0;
        end
        if (b > 0 && pg_free[b - 1]) begin
          h = b - 1;
          while (h > 0 && pg_len[h] == 0 && pg_free[h - 1]) h--;
          pg_len[h] += pg_len[b];
          pg_len[b] = 0;
        end
        st = cpa_pkg::ST_DONE;
      end
    end
    r.st = st;
    r.ab = pick[cpa_pkg::PAGE_W-1:0];
    r.tot = pg_total[cpa_pkg::LEN_W-1:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        errors++;
      end else begin
        alloc_result_t want;
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status);
          errors++;
        end
        if (alloc_base !== want.ab) begin
          $error("alloc_base expected %0d actual %0d", want.ab, alloc_base);
          errors++;
        end
        if (free_total !== want.tot) begin
          $error("free_total expected %0d actual %0d", want.tot, free_total);
          errors++;
        end
      end
    end
  end

  // one request transaction, then maybe a gap between bursts
  task automatic send_request(logic [1:0] kind, int b, int n, bit typed,
                              alloc_result_t typed_res);
    alloc_result_t pred;
    start <= 1'b1;
    req_type <= kind;
    base_page <= b[cpa_pkg::PAGE_W-1:0];
    page_count <= n[cpa_pkg::LEN_W-1:0];
    do @(posedge clk); while (busy);
    pred = page_request(kind, b, n);
    pending_results.push_back(typed ? typed_res : pred);
    n_items++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // policy write, only with the block idle
  task automatic write_policy(bit v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fit_best = v;
  endtask

  // pick a reserved range of up to max_n pages, found from a random page
  task automatic pick_reserved(int max_n, output int b, output int n);
    int p;
    p = $urandom_range(0, NP - 1);
    n = 0;
    b = p;
    for (int k = 0; k < NP; k++) begin
      if (!pg_free[(p + k) % NP]) begin
        b = (p + k) % NP;
        n = 1;
        break;
      end
    end
    if (n == 0) return;
    while (n < max_n && b + n < NP && !pg_free[b + n]) n++;
  endtask

  req_row_t dir_rows [22] = '{
    '{cpa_pkg::REQ_ALLOC, 0, 1, 1, cpa_pkg::ST_NOFIT, 0, 0},
    '{cpa_pkg::REQ_INIT, 5, 0, 1, cpa_pkg::ST_BAD, 0, 0},
    '{REQ_BOGUS, 1023, 2047, 1, cpa_pkg::ST_BAD, 0, 0},
    '{cpa_pkg::REQ_INIT, 1020, 10, 1, cpa_pkg::ST_BAD, 0, 0},
    '{cpa_pkg::REQ_FREE, 1023, 1, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_INIT, 0, 1023, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_INIT, 0, 1, 1, cpa_pkg::ST_BAD, 0, 1024},
    '{cpa_pkg::REQ_ALLOC, 0, 2047, 1, cpa_pkg::ST_NOFIT, 0, 1024},
    '{cpa_pkg::REQ_ALLOC, 0, 1023, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_ALLOC, 0, 1, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 0, 1024, 1, cpa_pkg::ST_DONE, 0, 1024},
    '{cpa_pkg::REQ_ALLOC, 0, 1024, 1, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 0, 10, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 20, 10, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 12, 4, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 10, 2, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_ALLOC, 0, 3, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 1, 0, 1, cpa_pkg::ST_BAD, 0, 23},
    '{cpa_pkg::REQ_FREE, 1000, 30, 1, cpa_pkg::ST_BAD, 0, 23},
    '{cpa_pkg::REQ_FREE, 1023, 1, 0, cpa_pkg::ST_DONE, 0, 0},
    '{cpa_pkg::REQ_FREE, 4, 2, 1, cpa_pkg::ST_BAD, 0, 24},
    '{cpa_pkg::REQ_ALLOC, 0, 20, 0, cpa_pkg::ST_DONE, 0, 0}
  };

  initial begin
    alloc_result_t tr;
    int b, n, r;
    logic [1:0] kind;
    rst = 1;
    start = 0;
    req_type = cpa_pkg::REQ_INIT;
    base_page = '0;
    page_count = '0;
    cfg_valid = 0;
    cfg_data = 0;
    pg_total = 0;
    fit_best = 0;
    for (int i = 0; i < NP; i++) begin
      pg_free[i] = 0;
      pg_len[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_policy(1'b0);

    // directed table
    foreach (dir_rows[i]) begin
      tr.st = dir_rows[i].st;
      tr.ab = dir_rows[i].ab[cpa_pkg::PAGE_W-1:0];
      tr.tot = dir_rows[i].tot[cpa_pkg::LEN_W-1:0];
      send_request(dir_rows[i].kind, dir_rows[i].b, dir_rows[i].n,
                   dir_rows[i].typed, tr);
    end

    // random phases, alternating fit policy
    for (int ph = 0; ph < 4; ph++) begin
      write_policy(ph % 2 == 0);
      for (int k = 0; k < 140; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          kind = cpa_pkg::REQ_ALLOC;
          b = $urandom_range(0, NP - 1);
          r = $urandom_range(0, 99);
          n = (r < 80) ? $urandom_range(1, 16) :
              (r < 95) ? $urandom_range(17, 200) : $urandom_range(201, 2047);
        end else if (r < 88) begin
          kind = (r < 80) ? cpa_pkg::REQ_FREE : cpa_pkg::REQ_INIT;
          pick_reserved($urandom_range(1, 32), b, n);
        end else if (r < 96) begin
          // broken range: zero size, past the end, or over a free page
          kind = $urandom_range(0, 1) ? cpa_pkg::REQ_FREE : cpa_pkg::REQ_INIT;
          r = $urandom_range(0, 2);
          b = $urandom_range(0, NP - 1);
          n = (r == 0) ? 0 : (r == 1) ? NP - b + $urandom_range(1, 20) :
              $urandom_range(1, 8);
        end else begin
          kind = 2'($urandom_range(0, 3));
          b = $urandom_range(0, NP - 1);
          n = $urandom_range(0, 2047);
        end
        send_request(kind, b, n, 0, tr);
      end
    end

    // drain
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    $display("Ran %0d requests (%0d results) through first-fit and best-fit phases,",
             n_items, n_results);
    $display("covering init, alloc, merging free and rejected requests.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* contiguous_page_allocator.f */
src/cpa_pkg.sv
src/cpa_ram.sv
src/cpa_datapath.sv
src/cpa_ctrl.sv
src/contiguous_page_allocator.sv
sim/testbench.sv
